// ===== hw/rtl/plal_pkg.sv =====
// ============================================================================
// plal_pkg
// Shared widths, opcodes, sequencer states and helpers for the polyline
// arc-length locator.
// ============================================================================
package plal_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;

  localparam int unsigned IDX_W   = 10;  // point_index / seg_index
  localparam int unsigned CNT_W   = 11;  // point_count and walk counter
  localparam int unsigned COORD_W = 32;  // Q16.16 coordinate
  localparam int unsigned DIST_W  = 48;  // Q32.16 arc length
  localparam int unsigned MAG_W   = 32;  // |dx|, |dy|
  localparam int unsigned MUL_A_W = 48;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned SQ_W    = 2 * MAG_W;
  localparam int unsigned RAD_W   = SQ_W + 2;
  localparam int unsigned ROOT_W  = RAD_W / 2;
  localparam int unsigned QUO_W   = 32;

  localparam logic [DIST_W-1:0] DIST_MAX    = '1;
  localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_S,
    ST_CAP_S,
    ST_CAP_J,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_CMP,
    ST_MULX,
    ST_DIVX,
    ST_MULY,
    ST_DIVY,
    ST_FIN
  } plal_state_t;

  // next vertex on the closed path
  function automatic logic [CNT_W-1:0] wrap_next(input logic [CNT_W-1:0] i,
                                                  input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] s;
    s = i + CNT_W'(1);
    return (s == n) ? '0 : s;
  endfunction

endpackage

// ===== hw/rtl/plal_ram.sv =====
// ============================================================================
// plal_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module plal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/plal_mul.sv =====
// ============================================================================
// plal_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// ============================================================================
module plal_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [plal_pkg::MUL_A_W-1:0] a,
  input  logic [plal_pkg::MUL_B_W-1:0] b,
  output logic                         done,
  output logic [plal_pkg::PROD_W-1:0]  prod
);

  localparam int unsigned CW = $clog2(plal_pkg::MUL_B_W);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [plal_pkg::MUL_A_W-1:0] a_r, a_nxt;
  logic [plal_pkg::MUL_B_W-1:0] b_r, b_nxt;
  logic [plal_pkg::PROD_W-1:0]  acc_r, acc_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(plal_pkg::MUL_B_W - 1);
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = {acc_r[plal_pkg::PROD_W-2:0], 1'b0}
              + (b_r[plal_pkg::MUL_B_W-1] ? plal_pkg::PROD_W'(a_r) : '0);
      b_nxt   = {b_r[plal_pkg::MUL_B_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== hw/rtl/plal_sqrt.sv =====
// ============================================================================
// plal_sqrt
// Digit-by-digit integer square root, one root bit per cycle (truncated).
// ============================================================================
module plal_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [plal_pkg::RAD_W-1:0]  radicand,
  output logic                        done,
  output logic [plal_pkg::ROOT_W-1:0] root
);

  localparam int unsigned RW = plal_pkg::ROOT_W + 1;  // remainder <= 2*root
  localparam int unsigned TW = RW + 2;
  localparam int unsigned CW = $clog2(plal_pkg::ROOT_W);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [plal_pkg::RAD_W-1:0]  rad_r, rad_nxt;
  logic [RW-1:0]               rem_r, rem_nxt;
  logic [plal_pkg::ROOT_W-1:0] root_r, root_nxt;
  logic [TW-1:0]               t_rem, trial, diff;

  always_comb begin
    t_rem    = {rem_r, rad_r[plal_pkg::RAD_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    diff     = t_rem - trial;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(plal_pkg::ROOT_W - 1);
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[plal_pkg::RAD_W-3:0], 2'b00};
      if (t_rem >= trial) begin
        rem_nxt  = diff[RW-1:0];
        root_nxt = {root_r[plal_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = t_rem[RW-1:0];
        root_nxt = {root_r[plal_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== hw/rtl/plal_div.sv =====
// ============================================================================
// plal_div
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit QUO_W bits, so the upper dividend part starts as the remainder.
// ============================================================================
module plal_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [plal_pkg::ROOT_W-1:0] num_hi,
  input  logic [plal_pkg::QUO_W-1:0]  num_lo,
  input  logic [plal_pkg::ROOT_W-1:0] den,
  output logic                        done,
  output logic [plal_pkg::QUO_W-1:0]  quot
);

  localparam int unsigned CW = $clog2(plal_pkg::QUO_W);
  localparam int unsigned TW = plal_pkg::ROOT_W + 1;

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [plal_pkg::ROOT_W-1:0] rem_r, rem_nxt;
  logic [plal_pkg::ROOT_W-1:0] den_r, den_nxt;
  logic [plal_pkg::QUO_W-1:0]  lo_r, lo_nxt;
  logic [plal_pkg::QUO_W-1:0]  q_r, q_nxt;
  logic [TW-1:0]               t_rem, diff;

  always_comb begin
    t_rem    = {rem_r, lo_r[plal_pkg::QUO_W-1]};
    diff     = t_rem - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(plal_pkg::QUO_W - 1);
      rem_nxt  = num_hi;
      den_nxt  = den;
      lo_nxt   = num_lo;
      q_nxt    = '0;
    end else if (busy_r) begin
      lo_nxt = {lo_r[plal_pkg::QUO_W-2:0], 1'b0};
      if (t_rem >= {1'b0, den_r}) begin
        rem_nxt = diff[plal_pkg::ROOT_W-1:0];
        q_nxt   = {q_r[plal_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = t_rem[plal_pkg::ROOT_W-1:0];
        q_nxt   = {q_r[plal_pkg::QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== hw/rtl/polyline_arc_length_locate_core.sv =====
// ============================================================================
// polyline_arc_length_locate_core
// Closed-polyline store with arc-length lookup and point interpolation.
// ============================================================================
//   channel | dir | handshake          | payload
//   in_     | in  | in_valid/in_stall  | opcode, point_index, point_x/y,
//           |     |                    | start_dist, target_dist
//   out_    | out | out_valid/out_stall| found, seg_index, seg_start_dist,
//           |     |                    | center_x/y
//   cfg_    | in  | cfg_valid/cfg_ready| point_count
//
// A query walks the segments from point_index on; each segment walked needs two
// squares on the bit-serial multiplier and a square root, and the hit segment
// then needs two more products and two divisions.
// Vertices sit in two RAMs read one vertex per cycle; no clearing pass.
// Synchronous active-low reset clears control only. A new request is taken
// while a finished result waits in the output register.
// ============================================================================
module polyline_arc_length_locate_core #(
  parameter int unsigned MAX_POINTS = plal_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic [plal_pkg::IDX_W-1:0]          in_point_index,
  input  logic signed [plal_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [plal_pkg::COORD_W-1:0] in_point_y,
  input  logic [plal_pkg::DIST_W-1:0]         in_start_dist,
  input  logic [plal_pkg::DIST_W-1:0]         in_target_dist,
  // result
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic [plal_pkg::IDX_W-1:0]          out_seg_index,
  output logic [plal_pkg::DIST_W-1:0]         out_seg_start_dist,
  output logic signed [plal_pkg::COORD_W-1:0] out_center_x,
  output logic signed [plal_pkg::COORD_W-1:0] out_center_y,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [plal_pkg::CNT_W-1:0]          cfg_point_count
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = plal_pkg::CNT_W;
  localparam int unsigned XW = plal_pkg::COORD_W;
  localparam int unsigned DW = plal_pkg::DIST_W;
  localparam int unsigned MW = plal_pkg::MAG_W;

  plal_pkg::plal_state_t state_r, state_nxt;

  logic [CW-1:0] count_r;
  logic [CW-1:0] n_eff;
  logic          in_accept, is_query, is_write, idx_oob;

  logic [CW-1:0]           i_r, i_nxt, i_inc;
  logic [DW-1:0]           dist_r, dist_nxt, target_r, target_nxt;
  logic [XW-1:0]           sx_r, sx_nxt, sy_r, sy_nxt, jx_r, jy_r;
  logic [MW-1:0]           ax_r, ax_nxt, ay_r, ay_nxt;
  logic                    negx_r, negx_nxt, negy_r, negy_nxt;
  logic [plal_pkg::SQ_W-1:0]   sqx_r, sqx_nxt;
  logic [plal_pkg::ROOT_W-1:0] len_r, len_nxt;
  logic [plal_pkg::QUO_W-1:0]  qx_r, qx_nxt, qy_r, qy_nxt;
  logic                    found_r, found_nxt;

  logic          out_valid_r, out_found_r;
  logic [plal_pkg::IDX_W-1:0] out_idx_r;
  logic [DW-1:0] out_dist_r;
  logic [XW-1:0] out_cx_r, out_cy_r;
  logic          out_load, out_free;

  logic          ram_we, ram_re;
  logic [CW-1:0] rd_idx;
  logic [XW-1:0] rd_x, rd_y;

  logic                         mul_start, mul_done;
  logic [plal_pkg::MUL_A_W-1:0] mul_a;
  logic [plal_pkg::MUL_B_W-1:0] mul_b;
  logic [plal_pkg::PROD_W-1:0]  mul_prod;
  logic                         sqrt_start, sqrt_done;
  logic [plal_pkg::RAD_W-1:0]   rad;
  logic [plal_pkg::ROOT_W-1:0]  root;
  logic                         div_start, div_done;
  logic [plal_pkg::QUO_W-1:0]   quot;

  logic signed [XW:0] dxs, dys;
  logic [DW:0]        next_sum;
  logic [DW-1:0]      next_sat, off;
  logic               hit, last_seg;

  assign in_stall  = (state_r != plal_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = in_valid & ~in_stall;
  assign is_query  = in_accept & (in_opcode == plal_pkg::OP_QUERY);
  assign idx_oob   = ({22'b0, in_point_index} >= 32'(MAX_POINTS));
  assign is_write  = in_accept & (in_opcode == plal_pkg::OP_WRITE) & ~idx_oob;

  assign n_eff = (32'(count_r) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : count_r;

  // segment arithmetic
  assign dxs      = $signed({jx_r[XW-1], jx_r}) - $signed({sx_r[XW-1], sx_r});
  assign dys      = $signed({jy_r[XW-1], jy_r}) - $signed({sy_r[XW-1], sy_r});
  assign next_sum = {1'b0, dist_r} + (DW+1)'(len_r);
  assign next_sat = next_sum[DW] ? plal_pkg::DIST_MAX : next_sum[DW-1:0];
  assign hit      = (target_r >= dist_r) && (target_r < next_sat);
  assign off      = target_r - dist_r;
  assign i_inc    = i_r + CW'(1);
  assign last_seg = (i_inc == n_eff);
  assign out_free = ~out_valid_r | ~out_stall;
  assign rad      = plal_pkg::RAD_W'(sqx_r) + plal_pkg::RAD_W'(mul_prod[plal_pkg::SQ_W-1:0]);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plal_pkg::ST_IDLE: begin
        if (is_query) begin
          state_nxt = ({1'b0, in_point_index} >= n_eff) ? plal_pkg::ST_FIN
                                                       : plal_pkg::ST_RD_S;
        end
      end
      plal_pkg::ST_RD_S:  state_nxt = plal_pkg::ST_CAP_S;
      plal_pkg::ST_CAP_S: state_nxt = plal_pkg::ST_CAP_J;
      plal_pkg::ST_CAP_J: state_nxt = plal_pkg::ST_DIFF;
      plal_pkg::ST_DIFF:  state_nxt = plal_pkg::ST_SQX;
      plal_pkg::ST_SQX:   if (mul_done) state_nxt = plal_pkg::ST_SQY;
      plal_pkg::ST_SQY:   if (mul_done) state_nxt = plal_pkg::ST_SQRT;
      plal_pkg::ST_SQRT:  if (sqrt_done) state_nxt = plal_pkg::ST_CMP;
      plal_pkg::ST_CMP: begin
        if (hit) begin
          state_nxt = plal_pkg::ST_MULX;
        end else if (last_seg) begin
          state_nxt = plal_pkg::ST_FIN;
        end else begin
          state_nxt = plal_pkg::ST_CAP_J;
        end
      end
      plal_pkg::ST_MULX:  if (mul_done) state_nxt = plal_pkg::ST_DIVX;
      plal_pkg::ST_DIVX:  if (div_done) state_nxt = plal_pkg::ST_MULY;
      plal_pkg::ST_MULY:  if (mul_done) state_nxt = plal_pkg::ST_DIVY;
      plal_pkg::ST_DIVY:  if (div_done) state_nxt = plal_pkg::ST_FIN;
      plal_pkg::ST_FIN:   if (out_free) state_nxt = plal_pkg::ST_IDLE;
      default:            state_nxt = plal_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    i_nxt      = i_r;
    dist_nxt   = dist_r;
    target_nxt = target_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    ax_nxt     = ax_r;
    ay_nxt     = ay_r;
    negx_nxt   = negx_r;
    negy_nxt   = negy_r;
    sqx_nxt    = sqx_r;
    len_nxt    = len_r;
    qx_nxt     = qx_r;
    qy_nxt     = qy_r;
    found_nxt  = found_r;
    ram_re     = 1'b0;
    rd_idx     = i_r;
    mul_start  = 1'b0;
    mul_a      = plal_pkg::MUL_A_W'(ax_r);
    mul_b      = ax_r;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      plal_pkg::ST_IDLE: begin
        if (is_query) begin
          i_nxt      = CW'(in_point_index);
          dist_nxt   = in_start_dist;
          target_nxt = in_target_dist;
          found_nxt  = 1'b0;
        end
      end
      plal_pkg::ST_RD_S: begin
        ram_re = 1'b1;
      end
      plal_pkg::ST_CAP_S: begin
        sx_nxt = rd_x;
        sy_nxt = rd_y;
        ram_re = 1'b1;
        rd_idx = plal_pkg::wrap_next(i_r, n_eff);
      end
      plal_pkg::ST_DIFF: begin
        negx_nxt  = dxs[XW];
        negy_nxt  = dys[XW];
        ax_nxt    = dxs[XW] ? MW'(-dxs) : MW'(dxs);
        ay_nxt    = dys[XW] ? MW'(-dys) : MW'(dys);
        mul_start = 1'b1;
        mul_a     = plal_pkg::MUL_A_W'(ax_nxt);
        mul_b     = ax_nxt;
      end
      plal_pkg::ST_SQX: begin
        if (mul_done) begin
          sqx_nxt   = mul_prod[plal_pkg::SQ_W-1:0];
          mul_start = 1'b1;
          mul_a     = plal_pkg::MUL_A_W'(ay_r);
          mul_b     = ay_r;
        end
      end
      plal_pkg::ST_SQY: begin
        sqrt_start = mul_done;
      end
      plal_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          len_nxt = root;
        end
      end
      plal_pkg::ST_CMP: begin
        if (hit) begin
          mul_start = 1'b1;
          mul_a     = off;
          mul_b     = ax_r;
        end else begin
          dist_nxt = next_sat;
          if (!last_seg) begin
            i_nxt  = i_inc;
            sx_nxt = jx_r;
            sy_nxt = jy_r;
            ram_re = 1'b1;
            rd_idx = plal_pkg::wrap_next(i_inc, n_eff);
          end
        end
      end
      plal_pkg::ST_MULX: begin
        div_start = mul_done;
      end
      plal_pkg::ST_DIVX: begin
        if (div_done) begin
          qx_nxt    = quot;
          mul_start = 1'b1;
          mul_a     = off;
          mul_b     = ay_r;
        end
      end
      plal_pkg::ST_MULY: begin
        div_start = mul_done;
      end
      plal_pkg::ST_DIVY: begin
        if (div_done) begin
          qy_nxt    = quot;
          found_nxt = 1'b1;
        end
      end
      plal_pkg::ST_FIN: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plal_pkg::ST_IDLE;
      count_r     <= plal_pkg::COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_point_count;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    i_r      <= i_nxt;
    dist_r   <= dist_nxt;
    target_r <= target_nxt;
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    ax_r     <= ax_nxt;
    ay_r     <= ay_nxt;
    negx_r   <= negx_nxt;
    negy_r   <= negy_nxt;
    sqx_r    <= sqx_nxt;
    len_r    <= len_nxt;
    qx_r     <= qx_nxt;
    qy_r     <= qy_nxt;
    found_r  <= found_nxt;
    if (state_r == plal_pkg::ST_CAP_J) begin
      jx_r <= rd_x;
      jy_r <= rd_y;
    end
    if (out_load) begin
      out_found_r <= found_r;
      out_idx_r   <= found_r ? plal_pkg::IDX_W'(i_r) : '0;
      out_dist_r  <= found_r ? dist_r : '0;
      out_cx_r    <= found_r ? (negx_r ? sx_r - qx_r : sx_r + qx_r) : '0;
      out_cy_r    <= found_r ? (negy_r ? sy_r - qy_r : sy_r + qy_r) : '0;
    end
  end

  plal_ram #(.WIDTH(XW), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_point_index)),
    .wdata (in_point_x),
    .re    (ram_re),
    .raddr (AW'(rd_idx)),
    .rdata (rd_x)
  );

  plal_ram #(.WIDTH(XW), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_point_index)),
    .wdata (in_point_y),
    .re    (ram_re),
    .raddr (AW'(rd_idx)),
    .rdata (rd_y)
  );

  assign ram_we = is_write;

  plal_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  plal_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (rad),
    .done     (sqrt_done),
    .root     (root)
  );

  // quotient < |d| fits 32 bits, so product bits above 64 are zero
  plal_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num_hi (mul_prod[plal_pkg::QUO_W + plal_pkg::ROOT_W - 1:plal_pkg::QUO_W]),
    .num_lo (mul_prod[plal_pkg::QUO_W-1:0]),
    .den    (len_r),
    .done   (div_done),
    .quot   (quot)
  );

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_seg_index      = out_idx_r;
  assign out_seg_start_dist = out_dist_r;
  assign out_center_x       = out_cx_r;
  assign out_center_y       = out_cy_r;

endmodule
